### design/assert_macros.svh
// Assertion macros used by the notifier core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### design/itn_pkg.sv
// Package: constants and codes of the idle threshold notifier.
package itn_pkg;
	localparam int MaxListeners = 16;
	localparam int IdxW = $clog2(MaxListeners);
	localparam int CntW = $clog2(MaxListeners + 1);

	localparam logic [1:0] FUNC_ADD = 2'd0;
	localparam logic [1:0] FUNC_REMOVE = 2'd1;
	localparam logic [1:0] FUNC_ACTIVITY = 2'd2;
	localparam logic [1:0] FUNC_TICK = 2'd3;

	localparam logic [1:0] KIND_IDLE = 2'd0;
	localparam logic [1:0] KIND_BACK = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	localparam logic [1:0] TMR_LEAVE = 2'd0;
	localparam logic [1:0] TMR_STOP = 2'd1;
	localparam logic [1:0] TMR_RESTART = 2'd2;
endpackage

### design/idle_threshold_notifier_core.sv
// Top level: listener table in memory with a sequenced idle check.
// Sequence: each pass reads then evaluates every table entry (back pass and idle pass for a
// check, search plus shift for remove), between setup, done and handoff states; output stalls hold it.
// Flow: one item at a time; a new request is taken only after the previous result has been
// handed off, as the passes over the entry memory read one entry at a time.
// Reset: arst_n clears count, times, idle flags and the sequencer; ids and thresholds
// stay undefined until written.
`include "assert_macros.svh"
module idle_threshold_notifier_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [15:0] listener_id,
	input  logic [31:0] threshold_sec,
	input  logic [31:0] now_sec,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [15:0] notify_id,
	output logic [31:0] idle_sec,
	output logic [1:0]  status,
	output logic [1:0]  timer_cmd,
	output logic [31:0] timer_delay_sec,
	output logic        last
);
	import itn_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_ADD, S_CHK, S_BACK_RD, S_BACK_EV, S_IDL_RD, S_IDL_EV,
		S_REM_RD, S_REM_EV, S_SH_RD, S_SH_WR, S_DONE, S_WAIT
	} state_t;

	// Entry memory: id and threshold, one synchronous read port, one write port.
	logic [47:0] mem_q [MaxListeners];
	logic [47:0] rd_q;
	logic [IdxW-1:0] raddr;
	logic        we;
	logic [IdxW-1:0] waddr;
	logic [47:0] wdata;
	// Idle flags must reset, so they live in flip-flops.
	logic [MaxListeners-1:0] flag_q;

	state_t      st_q;
	logic [CntW-1:0] cnt_q;
	logic [IdxW-1:0] idx_q;
	logic [31:0] act_q, hand_q;
	logic [15:0] id_q;
	logic [31:0] thr_q, now_q, idle_q, best_q;
	logic        pend_q, noreset_q;
	logic [1:0]  st_res_q, cmd_q;

	logic [31:0] idle_n, earlier_n;
	logic [CntW-1:0] idx_ext;
	assign idle_n = now_q - act_q;
	assign earlier_n = now_q - hand_q;
	assign idx_ext = CntW'(idx_q);

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rd_q <= mem_q[raddr];
	end

	assign in_ready = (st_q == S_IDLE);

	// Reads and writes of the memory follow the sequencer state.
	always_comb begin
		raddr = idx_q;
		we = 1'b0;
		waddr = idx_q;
		wdata = {id_q, thr_q};
		case (st_q)
			S_ADD: begin
				we = 1'b1;
				waddr = cnt_q[IdxW-1:0];
			end
			S_SH_RD: raddr = IdxW'(idx_ext + 1'b1);
			S_SH_WR: begin
				we = 1'b1;
				wdata = rd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
			act_q <= '0;
			hand_q <= '0;
			flag_q <= '0;
			out_valid <= 1'b0;
			idx_q <= '0;
			pend_q <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						id_q <= listener_id;
						thr_q <= threshold_sec;
						now_q <= now_sec;
						idle_q <= '0;
						cmd_q <= TMR_LEAVE;
						st_res_q <= ST_OK;
						noreset_q <= 1'b0;
						pend_q <= 1'b0;
						idx_q <= '0;
						case (func)
							FUNC_ADD: begin
								if (threshold_sec == '0) begin
									st_res_q <= ST_ZERO;
									st_q <= S_DONE;
								end else if (cnt_q >= CntW'(MaxListeners)) begin
									st_res_q <= ST_FULL;
									st_q <= S_DONE;
								end else begin
									st_q <= S_ADD;
								end
							end
							FUNC_REMOVE: begin
								if (threshold_sec == '0) begin
									st_res_q <= ST_ZERO;
									st_q <= S_DONE;
								end else begin
									st_res_q <= ST_NOTFOUND;
									st_q <= (cnt_q == '0) ? S_DONE : S_REM_RD;
								end
							end
							FUNC_ACTIVITY: begin
								noreset_q <= (act_q != '0);
								act_q <= (now_sec != '0) ? now_sec : 32'd1;
								st_q <= S_CHK;
							end
							default: st_q <= S_CHK;
						endcase
					end
				end
				S_ADD: begin
					flag_q[cnt_q[IdxW-1:0]] <= 1'b0;
					cnt_q <= cnt_q + 1'b1;
					st_q <= S_CHK;
				end
				S_CHK: begin
					if (act_q == '0) begin
						st_q <= S_DONE;
					end else begin
						idle_q <= idle_n;
						hand_q <= act_q;
						idx_q <= '0;
						if (earlier_n > idle_n && cnt_q != '0) st_q <= S_BACK_RD;
						else if (noreset_q || cnt_q == '0) st_q <= S_DONE;
						else st_q <= S_IDL_RD;
					end
				end
				// Back pass: emit and clear each flagged entry in table order.
				S_BACK_RD: begin
					// Drop a notification that transfers during the read cycle.
					if (out_ready) out_valid <= 1'b0;
					st_q <= S_BACK_EV;
				end
				S_BACK_EV: begin
					if (!out_valid || out_ready) begin
						out_valid <= flag_q[idx_q] && !out_valid;
						if (flag_q[idx_q] && !out_valid) begin
							kind <= KIND_BACK;
							notify_id <= rd_q[47:32];
							idle_sec <= idle_q;
							status <= ST_OK;
							timer_cmd <= TMR_LEAVE;
							timer_delay_sec <= '0;
							last <= 1'b0;
							flag_q[idx_q] <= 1'b0;
						end
						if (!(flag_q[idx_q] && out_valid)) begin
							if (idx_ext + 1'b1 >= cnt_q) begin
								idx_q <= '0;
								st_q <= noreset_q ? S_DONE : S_IDL_RD;
							end else begin
								idx_q <= idx_q + 1'b1;
								st_q <= S_BACK_RD;
							end
						end
					end
				end
				// Idle pass: flag reached thresholds, track nearest pending one.
				S_IDL_RD: begin
					if (out_ready) out_valid <= 1'b0;
					st_q <= S_IDL_EV;
				end
				S_IDL_EV: begin
					if (!out_valid || out_ready) begin
						out_valid <= !flag_q[idx_q] && rd_q[31:0] <= idle_q && !out_valid;
						if (!flag_q[idx_q] && rd_q[31:0] <= idle_q && !out_valid) begin
							kind <= KIND_IDLE;
							notify_id <= rd_q[47:32];
							idle_sec <= idle_q;
							status <= ST_OK;
							timer_cmd <= TMR_LEAVE;
							timer_delay_sec <= '0;
							last <= 1'b0;
							flag_q[idx_q] <= 1'b1;
						end else if (!flag_q[idx_q] && rd_q[31:0] > idle_q &&
							(!pend_q || rd_q[31:0] < best_q)) begin
							best_q <= rd_q[31:0];
							pend_q <= 1'b1;
						end
						if (!(!flag_q[idx_q] && rd_q[31:0] <= idle_q && out_valid)) begin
							if (idx_ext + 1'b1 >= cnt_q) st_q <= S_DONE;
							else begin
								idx_q <= idx_q + 1'b1;
								st_q <= S_IDL_RD;
							end
						end
					end
				end
				// Remove: search first match, then shift later entries up.
				S_REM_RD: st_q <= S_REM_EV;
				S_REM_EV: begin
					if (rd_q == {id_q, thr_q}) begin
						st_res_q <= ST_OK;
						st_q <= (idx_ext + 1'b1 >= cnt_q) ? S_SH_WR : S_SH_RD;
					end else if (idx_ext + 1'b1 >= cnt_q) begin
						st_q <= S_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
						st_q <= S_REM_RD;
					end
				end
				S_SH_RD: st_q <= S_SH_WR;
				S_SH_WR: begin
					// Last slot: drop the entry and clear its flag.
					if (idx_ext + 1'b1 >= cnt_q) begin
						flag_q[idx_q] <= 1'b0;
						cnt_q <= cnt_q - 1'b1;
						if (cnt_q == CntW'(1)) cmd_q <= TMR_STOP;
						st_q <= S_DONE;
					end else begin
						flag_q[idx_q] <= flag_q[IdxW'(idx_ext + 1'b1)];
						idx_q <= idx_q + 1'b1;
						st_q <= (idx_ext + 2'd2 >= cnt_q) ? S_SH_WR : S_SH_RD;
					end
				end
				S_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						kind <= KIND_DONE;
						notify_id <= '0;
						idle_sec <= idle_q;
						status <= st_res_q;
						timer_cmd <= pend_q ? TMR_RESTART : cmd_q;
						timer_delay_sec <= pend_q ? (best_q - idle_q) : '0;
						last <= 1'b1;
						st_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= CntW'(MaxListeners), "count overflow")
	`ASSERT_IMP(a_idle_quiet, clk, arst_n, st_q == S_IDLE, !out_valid, "result while idle")
	`ASSERT_NXT(a_add_grows, clk, arst_n, st_q == S_ADD, cnt_q == $past(cnt_q) + 1'b1, "add lost")
endmodule
